// File: hdl/pli_pkg.sv
package pli_pkg;

  localparam int unsigned ValW  = 32;
  localparam int unsigned FracW = 16;
  localparam int unsigned CntW  = 9;
  localparam int unsigned IdxW  = 8;
  localparam int unsigned StepW = $clog2(FracW);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic [ValW-1:0] x;
    logic [ValW-1:0] y;
  } point_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LAST,
    ST_SCAN,
    ST_DIV,
    ST_MUL,
    ST_SUM,
    ST_OUT
  } state_e;

endpackage

// File: hdl/pli_ram.sv
module pli_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/piecewise_linear_table_interpolator.sv
// Piecewise-linear table interpolator.
// Input channel (in_valid_i / in_stall_o) carries one request: a write stores the
// point (key_x_i, point_y_i) at point_index_i, a query asks for y at key_x_i. Only
// queries produce a request on the output channel (out_valid_o / out_stall_i).
// The table lives in one synchronous RAM holding x and y side by side; the
// register point_count (cfg_we_i / cfg_data_i) sets how many points are in use.
// A write leaves the block idle, so it is ready again on the next cycle.
// A query reads entry 0, then the last entry in use. A key at or below the first
// x gives its y through ST_FIRST and ST_OUT, a key at or above the last x through
// ST_FIRST, ST_LAST and ST_OUT. Otherwise a linear scan reads one entry per cycle
// until it finds the interval i, followed by a restoring divide for the 16-bit
// fraction, a multiply, an add and the load of the output register. Latency grows
// with i; the scan through the RAM read port and the bit-per-cycle divider set it.
// One query is in flight at a time, and the next request is accepted in the cycle
// after its result is loaded. The output register holds a finished result while
// the receiver stalls, so the next request can still be accepted; a second query
// that completes meanwhile waits until the output register is free.
// Reset clears the control state and sets point_count to 2; table contents
// are undefined until written, and no clearing pass runs.
module piecewise_linear_table_interpolator
  import pli_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CntW-1:0]   cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              operation_i,
  input  logic [IdxW-1:0]   point_index_i,
  input  logic [ValW-1:0]   key_x_i,
  input  logic [ValW-1:0]   point_y_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ValW-1:0]   result_y_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  // Width able to hold both the 9-bit count and the depth itself.
  localparam int unsigned CW = (AW + 1 > CntW) ? AW + 1 : CntW;
  localparam int unsigned ProdW = ValW + FracW;
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] MinCnt = CW'(2);

  state_e state_q, state_d;

  logic [CntW-1:0]  point_count_q;
  logic [ValW-1:0]  key_q;
  point_t           prev_q;
  logic [ValW-1:0]  next_y_q;
  logic [AW-1:0]    scan_q;
  logic [ValW-1:0]  rem_q;
  logic [ValW-1:0]  span_q;
  logic [FracW-1:0] frac_q;
  logic [StepW-1:0] step_q;
  logic [ProdW-1:0] part_q;
  logic [ValW-1:0]  res_q;
  logic [ValW-1:0]  out_q;
  logic             out_valid_q;

  // Control outputs of the sequencer.
  logic          in_accept;
  logic          ram_we;
  logic [AW-1:0] rd_addr;
  logic          out_load;

  point_t        rd_point;
  logic [CW-1:0] cnt_ext, cnt_sat;
  logic [AW-1:0] last_idx;
  logic          scan_hit;
  logic [ValW:0] rem_shift;
  logic          rem_ge;

  // The count in use saturates to the range two through the table depth.
  assign cnt_ext  = CW'(point_count_q);
  assign cnt_sat  = (cnt_ext < MinCnt) ? MinCnt : ((cnt_ext > DepthC) ? DepthC : cnt_ext);
  assign last_idx = AW'(cnt_sat - CW'(1));

  assign in_accept = in_valid_i && !in_stall_o;
  assign scan_hit  = (key_q < rd_point.x) || (scan_q == last_idx);
  assign rem_shift = {rem_q, 1'b0};
  assign rem_ge    = rem_shift >= {1'b0, span_q};

  pli_ram #(
    .WIDTH($bits(point_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AW'(point_index_i)),
    .wdata_i({key_x_i, point_y_i}),
    .raddr_i(rd_addr),
    .rdata_o(rd_point)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept && operation_i == OP_QUERY) begin
          state_d = ST_FIRST;
        end
      end
      ST_FIRST: begin
        state_d = (key_q <= rd_point.x) ? ST_OUT : ST_LAST;
      end
      ST_LAST: begin
        state_d = (key_q >= rd_point.x) ? ST_OUT : ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_hit) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (step_q == '0) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_SUM;
      ST_SUM:  state_d = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o = 1'b1;
    ram_we     = 1'b0;
    rd_addr    = '0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        // Writes beyond the table depth are dropped.
        ram_we = in_valid_i && operation_i == OP_WRITE &&
                 (32'(point_index_i) < TABLE_DEPTH);
      end
      ST_FIRST: rd_addr = last_idx;
      ST_LAST:  rd_addr = AW'(1);
      ST_SCAN:  rd_addr = scan_q + AW'(1);
      ST_OUT:   out_load = !out_valid_q || !out_stall_i;
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      out_valid_q   <= 1'b0;
      point_count_q <= CntW'(2);
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        point_count_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        key_q <= key_x_i;
      end
      ST_FIRST: begin
        prev_q <= rd_point;
        res_q  <= rd_point.y;
      end
      ST_LAST: begin
        res_q  <= rd_point.y;
        scan_q <= AW'(1);
      end
      ST_SCAN: begin
        if (scan_hit) begin
          // The interval always satisfies x[i] <= key < x[i+1].
          next_y_q <= rd_point.y;
          span_q   <= rd_point.x - prev_q.x;
          rem_q    <= key_q - prev_q.x;
          step_q   <= StepW'(FracW - 1);
        end else begin
          prev_q <= rd_point;
          scan_q <= scan_q + AW'(1);
        end
      end
      ST_DIV: begin
        // Restoring division, one fraction bit per cycle.
        rem_q  <= rem_ge ? ValW'(rem_shift - {1'b0, span_q}) : rem_shift[ValW-1:0];
        frac_q <= {frac_q[FracW-2:0], rem_ge};
        step_q <= step_q - StepW'(1);
      end
      ST_MUL: begin
        if (next_y_q >= prev_q.y) begin
          part_q <= ProdW'(next_y_q - prev_q.y) * ProdW'(frac_q);
        end else begin
          part_q <= ProdW'(prev_q.y - next_y_q) * ProdW'(frac_q);
        end
      end
      ST_SUM: begin
        if (next_y_q >= prev_q.y) begin
          res_q <= prev_q.y + part_q[ProdW-1:FracW];
        end else if (part_q[ProdW-1:FracW] > prev_q.y) begin
          res_q <= '0;
        end else begin
          res_q <= prev_q.y - part_q[ProdW-1:FracW];
        end
      end
      default: begin
        rem_q <= rem_q;
      end
    endcase
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_y_o  = out_q;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import pli_pkg::*;

  // The table is sized as in the block. The settle time covers the longest
  // query (a scan over every point, then divide, multiply, add and output).
  localparam int unsigned TABLE_DEPTH   = 256;
  localparam int unsigned SETTLE_CYCLES = TABLE_DEPTH + 24;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned RANDOM_ITEMS  = 1850;

  // A directed row is either a request or a point_count write. In a
  // point_count row the new count sits in the low bits of the x field.
  typedef enum logic {
    ROW_REQUEST,
    ROW_POINT_COUNT
  } row_kind_e;

  typedef struct packed {
    row_kind_e       kind;
    logic            op;
    logic [IdxW-1:0] idx;
    logic [ValW-1:0] x;
    logic [ValW-1:0] y;
    logic            fixed_want;
    logic [ValW-1:0] want_y;
  } dir_row_t;

  // Directed part. The literal result is given only where it is obvious:
  // clamps at or below the first point and at or above the last one. Rows with
  // fixed_want low are checked against the interpolation predictor.
  localparam dir_row_t DIRECTED_ROWS [22] = '{
    // Two points, y rising over the full range.
    '{ROW_REQUEST, OP_WRITE, 8'd0, 32'h0001_0000, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_REQUEST, OP_WRITE, 8'd1, 32'h0003_0000, 32'hFFFF_FFFF, 1'b0, 32'h0},
    // Below and at the first x, above and at the last x.
    '{ROW_REQUEST, OP_QUERY, 8'hFF, 32'h0000_0000, 32'hDEAD_BEEF, 1'b1, 32'h0000_0000},
    '{ROW_REQUEST, OP_QUERY, 8'hA5, 32'h0001_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{ROW_REQUEST, OP_QUERY, 8'h5A, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
    '{ROW_REQUEST, OP_QUERY, 8'h00, 32'h0003_0000, 32'h1234_5678, 1'b1, 32'hFFFF_FFFF},
    // Inside the interval: midpoint, smallest and largest fraction.
    '{ROW_REQUEST, OP_QUERY, 8'h01, 32'h0002_0000, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_REQUEST, OP_QUERY, 8'h80, 32'h0001_0001, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_REQUEST, OP_QUERY, 8'h7F, 32'h0002_FFFF, 32'h0000_0000, 1'b0, 32'h0},
    // Full-range x with falling y.
    '{ROW_REQUEST, OP_WRITE, 8'd0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{ROW_REQUEST, OP_WRITE, 8'd1, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_REQUEST, OP_QUERY, 8'h00, 32'h8000_0000, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_REQUEST, OP_QUERY, 8'h00, 32'hFFFF_FFFE, 32'h0000_0000, 1'b0, 32'h0},
    // Top index, outside the points in use.
    '{ROW_REQUEST, OP_WRITE, 8'd255, 32'hFFFF_FFFF, 32'h1234_5678, 1'b0, 32'h0},
    // Three points that do not ascend: x = 0, max, 2.0.
    '{ROW_POINT_COUNT, OP_WRITE, 8'd0, 32'd3, 32'h0, 1'b0, 32'h0},
    '{ROW_REQUEST, OP_WRITE, 8'd2, 32'h0002_0000, 32'h0000_1000, 1'b0, 32'h0},
    '{ROW_REQUEST, OP_QUERY, 8'h00, 32'h0001_0000, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_REQUEST, OP_QUERY, 8'h00, 32'h0002_0000, 32'h0000_0000, 1'b1, 32'h0000_1000},
    // Counts below two saturate to two points.
    '{ROW_POINT_COUNT, OP_WRITE, 8'd0, 32'd0, 32'h0, 1'b0, 32'h0},
    '{ROW_REQUEST, OP_QUERY, 8'h00, 32'h0002_0000, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_POINT_COUNT, OP_WRITE, 8'd0, 32'd1, 32'h0, 1'b0, 32'h0},
    '{ROW_REQUEST, OP_QUERY, 8'h00, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000}
  };

  // Point counts of the first random phases: the extremes of the register,
  // both saturation sides and a few ordinary sizes. Later phases pick at
  // random, mostly small tables so that queries stay short.
  localparam logic [CntW-1:0] PHASE_COUNTS [10] = '{
    9'd2, 9'd511, 9'd3, 9'd0, 9'd257, 9'd1, 9'd256, 9'd4, 9'd17, 9'd300
  };

  typedef enum logic [1:0] {
    RX_READY,
    RX_RANDOM,
    RX_SLOW
  } rx_mode_e;

  logic            clk_i         = 1'b0;
  logic            rst_ni        = 1'b0;
  logic            cfg_we_i      = 1'b0;
  logic [CntW-1:0] cfg_data_i    = '0;
  logic            in_valid_i    = 1'b0;
  logic            in_stall_o;
  logic            operation_i   = OP_WRITE;
  logic [IdxW-1:0] point_index_i = '0;
  logic [ValW-1:0] key_x_i       = '0;
  logic [ValW-1:0] point_y_i     = '0;
  logic            out_valid_o;
  logic            out_stall_i   = 1'b0;
  logic [ValW-1:0] result_y_o;

  // Shadow of the table and of point_count, updated as requests are accepted.
  logic [ValW-1:0] shadow_x [TABLE_DEPTH];
  logic [ValW-1:0] shadow_y [TABLE_DEPTH];
  logic [CntW-1:0] shadow_count = 9'd2;

  // Interpolated values still owed by the block, oldest first.
  logic [ValW-1:0] owed_y [$];

  int burst_left      = 0;
  int requests_sent   = 0;
  int table_writes    = 0;
  int results_checked = 0;
  int count_settings  = 0;
  int fail_count      = 0;
  int quiet_cycles    = 0;

  rx_mode_e rx_mode      = RX_READY;
  int       rx_mode_left = 0;

  piecewise_linear_table_interpolator #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .point_index_i (point_index_i),
    .key_x_i       (key_x_i),
    .point_y_i     (point_y_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_y_o    (result_y_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Number of points the block actually uses: the register saturates to
  // the range two to TABLE_DEPTH.
  function automatic int unsigned points_in_use();
    int unsigned used;
    used = shadow_count;
    if (used < 2) used = 2;
    if (used > TABLE_DEPTH) used = TABLE_DEPTH;
    return used;
  endfunction

  // Interpolated y at q from the shadow table. The interval is the lowest i
  // with q < x[i+1]; since q is above x[0] it always has a nonzero width,
  // even when the table does not ascend.
  function automatic logic [ValW-1:0] interpolate_y(input logic [ValW-1:0] q);
    int unsigned     last_i;
    int unsigned     i;
    logic [ValW-1:0] x0, x1, y0, y1, diff;
    logic [63:0]     span, offs, frac, part, sum;
    last_i = points_in_use() - 1;
    if (q <= shadow_x[0]) return shadow_y[0];
    if (q >= shadow_x[last_i]) return shadow_y[last_i];
    i = 0;
    while (i + 1 < last_i && !(q < shadow_x[i+1])) i++;
    x0 = shadow_x[i];
    x1 = shadow_x[i+1];
    y0 = shadow_y[i];
    y1 = shadow_y[i+1];
    if (x1 <= x0 || q < x0) return y0;
    span = {32'b0, x1} - {32'b0, x0};
    offs = {32'b0, q} - {32'b0, x0};
    // Unsigned Q0.16 fraction, truncated.
    frac = (offs << FracW) / span;
    if (frac > 64'h0000_FFFF) frac = 64'h0000_FFFF;
    if (y1 >= y0) begin
      diff = y1 - y0;
      part = ({32'b0, diff} * frac) >> FracW;
      sum  = {32'b0, y0} + part;
      if (sum > 64'h0000_0000_FFFF_FFFF) sum = 64'h0000_0000_FFFF_FFFF;
      return sum[ValW-1:0];
    end
    diff = y0 - y1;
    part = ({32'b0, diff} * frac) >> FracW;
    if (part > {32'b0, y0}) return '0;
    sum = {32'b0, y0} - part;
    return sum[ValW-1:0];
  endfunction

  // Presents one request and holds it until it is accepted. The sender works
  // in bursts; at the end of each burst valid drops for a random gap. Valid
  // stays high from one request to the next inside a burst, so it gets only
  // one assignment per falling edge.
  task automatic send_request(input logic            op,
                              input logic [IdxW-1:0] idx,
                              input logic [ValW-1:0] x,
                              input logic [ValW-1:0] y,
                              input logic            fixed_want = 1'b0,
                              input logic [ValW-1:0] want_y = '0);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 16);
    end
    @(negedge clk_i);
    in_valid_i    = 1'b1;
    operation_i   = op;
    point_index_i = idx;
    key_x_i       = x;
    point_y_i     = y;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    requests_sent++;
    // The request is accepted at this edge; apply it to the shadow state.
    if (op == OP_WRITE) begin
      shadow_x[idx] = x;
      shadow_y[idx] = y;
      table_writes++;
    end else begin
      owed_y.push_back(fixed_want ? want_y : interpolate_y(x));
    end
  endtask

  // Stops sending, waits for every owed result and then for the longest
  // query, so that the block is surely idle.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    burst_left = 0;
    while (owed_y.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // point_count is written only on an idle block.
  task automatic set_point_count(input logic [CntW-1:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i     = 1'b0;
    shadow_count = value;
    count_settings++;
  endtask

  // Writes every point in use. Most tables ascend with steps of a random
  // scale, from huge to a few LSBs; one in ten gets random x values.
  task automatic fill_table(input int unsigned used);
    logic [ValW-1:0] step_lim;
    logic [ValW-1:0] xk;
    logic            scrambled;
    int              shift;
    step_lim  = 32'hFFFF_FFFF / (used + 1);
    scrambled = ($urandom_range(0, 9) == 0);
    shift     = $urandom_range(0, 20);
    xk        = ($urandom_range(0, 3) == 0) ? '0 : $urandom % step_lim;
    for (int k = 0; k < used; k++) begin
      send_request(OP_WRITE, IdxW'(k), scrambled ? ValW'($urandom) : xk,
                   ($urandom_range(0, 3) == 0) ? ($urandom & 32'h0000_FFFF)
                                               : ValW'($urandom));
      xk = xk + 1 + (($urandom % step_lim) >> shift);
    end
  endtask

  // Receiver: alternates between stretches of its own: always ready, stalling
  // at random, and stalling most of the time.
  always @(negedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_e'($urandom_range(0, 2));
      rx_mode_left = $urandom_range(16, 160);
    end else begin
      rx_mode_left--;
    end
    case (rx_mode)
      RX_READY:  out_stall_i <= 1'b0;
      RX_RANDOM: out_stall_i <= ($urandom_range(0, 1) == 1);
      default:   out_stall_i <= ($urandom_range(0, 5) != 0);
    endcase
  end

  // Every accepted result is compared with the oldest owed value.
  always @(posedge clk_i) begin : check_result
    logic [ValW-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (owed_y.size() == 0) begin
        $error("result_y: no result expected, actual %h", result_y_o);
        fail_count++;
      end else begin
        want = owed_y.pop_front();
        results_checked++;
        if (result_y_o !== want) begin
          $error("result_y: expected %h, actual %h", want, result_y_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    int              random_items;
    int              phase;
    int              mix;
    int              k;
    int unsigned     used;
    logic [CntW-1:0] count;
    logic [ValW-1:0] key;
    random_items = 0;
    phase        = 0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DIRECTED_ROWS[r]) begin
      if (DIRECTED_ROWS[r].kind == ROW_POINT_COUNT) begin
        set_point_count(DIRECTED_ROWS[r].x[CntW-1:0]);
      end else begin
        send_request(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].idx, DIRECTED_ROWS[r].x,
                     DIRECTED_ROWS[r].y, DIRECTED_ROWS[r].fixed_want,
                     DIRECTED_ROWS[r].want_y);
      end
    end

    // Random phases: set a count on the idle block, fill every point in use,
    // then mix queries with writes that mostly keep the table ascending.
    while (random_items < RANDOM_ITEMS) begin
      if (phase < $size(PHASE_COUNTS)) begin
        count = PHASE_COUNTS[phase];
      end else if ($urandom_range(0, 7) == 0) begin
        count = $urandom_range(0, 511);
      end else begin
        count = $urandom_range(2, 12);
      end
      set_point_count(count);
      used = points_in_use();
      fill_table(used);
      mix = $urandom_range(30, 90);
      repeat (mix) begin
        k = $urandom_range(0, used - 1);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6: begin
            // Queries: anywhere, clamped low, clamped high, exactly on a
            // point, and most often a key within an interval.
            case ($urandom_range(0, 5))
              0:       key = $urandom;
              1:       key = $urandom_range(0, shadow_x[0]);
              2:       key = $urandom_range(shadow_x[used-1], 32'hFFFF_FFFF);
              3:       key = shadow_x[k];
              default: key = (k + 1 < used) ? $urandom_range(shadow_x[k], shadow_x[k+1])
                                            : $urandom;
            endcase
            send_request(OP_QUERY, IdxW'($urandom), key, $urandom);
          end
          7, 8: begin
            // Move one inner point between its neighbors, if there is room.
            if (k > 0 && k + 1 < used && shadow_x[k+1] > shadow_x[k-1] &&
                shadow_x[k+1] - shadow_x[k-1] > 1) begin
              send_request(OP_WRITE, IdxW'(k),
                           $urandom_range(shadow_x[k-1] + 1, shadow_x[k+1] - 1),
                           $urandom);
            end else begin
              send_request(OP_WRITE, IdxW'($urandom), $urandom, $urandom);
            end
          end
          default: begin
            send_request(OP_WRITE, IdxW'($urandom), $urandom, $urandom);
          end
        endcase
      end
      random_items += used + mix;
      phase++;
    end

    drain_results();
    $display("Sent %0d requests (%0d table writes) over %0d point_count settings.",
             requests_sent, table_writes, count_settings);
    $display("Checked %0d interpolated results.", results_checked);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/pli_pkg.sv
hdl/pli_ram.sv
hdl/piecewise_linear_table_interpolator.sv
tb/tb.sv
